// ===== rtl/bpac_pkg.sv =====
// ----------------------------------------------------------------------------
// bpac_pkg
// Shared types, constants and helpers for the bump page allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpac_pkg;

  localparam int PAGE_BYTES_MAX     = 65536;
  localparam int ALIGN_BYTES        = 16;
  localparam int BLOCK_HEADER_BYTES = 16;
  localparam int PAGE_HEADER_BYTES  = 64;
  localparam int POINTER_BYTES      = 8;
  localparam int TYPE_BITS          = 4;

  localparam int HDR_DEPTH = PAGE_BYTES_MAX / ALIGN_BYTES + 1;
  localparam int HDR_AW    = $clog2(HDR_DEPTH);
  localparam int ALIGN_SH  = $clog2(ALIGN_BYTES);

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_BAD_FREE = 2'd2;

  // Opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // One block header as stored in the header memory
  typedef struct packed {
    logic                 written;
    logic [15:0]          size;
    logic                 occupied;
    logic [TYPE_BITS-1:0] btype;
    logic [15:0]          prev;
    logic                 prev_valid;
  } hdr_t;

  // Operands of the shared offset adder
  typedef struct packed {
    logic [16:0] a;
    logic [15:0] b;
  } add_req_t;

  typedef struct packed {
    logic [17:0] sum;
    logic        below_bump;
  } add_rsp_t;

  // Map a byte offset to a header slot, clamped to the last slot
  function automatic logic [HDR_AW-1:0] hdr_idx(input logic [17:0] off);
    logic [17:0] slot;
    slot = off >> ALIGN_SH;
    if (slot >= 18'(HDR_DEPTH)) begin
      return HDR_AW'(HDR_DEPTH - 1);
    end
    return slot[HDR_AW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bpac_hdr_mem.sv =====
// ----------------------------------------------------------------------------
// bpac_hdr_mem
// Block header memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bpac_hdr_mem (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [bpac_pkg::HDR_AW-1:0] waddr,
  input  wire bpac_pkg::hdr_t            wdata,
  input  wire logic [bpac_pkg::HDR_AW-1:0] raddr,
  output bpac_pkg::hdr_t                 rdata
);
  import bpac_pkg::*;

  hdr_t mem [0:HDR_DEPTH-1];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/bpac_addu.sv =====
// ----------------------------------------------------------------------------
// bpac_addu
// Shared offset adder: a + b + block header, compared against bump pointer.
// ----------------------------------------------------------------------------
`default_nettype none

module bpac_addu (
  input  wire bpac_pkg::add_req_t req,
  input  wire logic [16:0]        bump,
  output bpac_pkg::add_rsp_t      rsp
);
  import bpac_pkg::*;

  // Add operands plus one header, flag results below the bump pointer
  always_comb begin
    rsp.sum        = {1'b0, req.a} + {2'b00, req.b} + 18'(BLOCK_HEADER_BYTES);
    rsp.below_bump = rsp.sum < {1'b0, bump};
  end

endmodule

`default_nettype wire

// ===== rtl/bump_page_allocator_coalesce.sv =====
// ----------------------------------------------------------------------------
// bump_page_allocator_coalesce
// Bump pointer page allocator that merges freed blocks with free neighbors.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with opcode and its operands while busy is low. An allocate
//   answers from S_ALLOC. A free checks the offset in S_FCHK, reads the block
//   header and the neighbor headers through the registered read port, then
//   rewrites those that change, and ends in S_ROLL. A bad offset answers from
//   S_FCHK, a block that is not occupied from S_FB.
//   One beat of result (status, data_offset, granted_bytes, page_empty,
//   page_full) shows on the cycle done is high, and only then; the receiver
//   cannot stall it. busy stays high from the accepting edge until the edge
//   that raises done.
//   cfg_wr_en with cfg_wr_data sets the page size and restarts the page;
//   write it only while idle.
//   Reset sets the page size to 64 KiB, the bump pointer to the page header
//   end, and forgets all blocks. After reset and after each page size write
//   the header memory is cleared one slot per cycle, busy high until all 4097
//   slots are clear, so a free never finds a header from an earlier page.
// ----------------------------------------------------------------------------
`default_nettype none

module bump_page_allocator_coalesce (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        opcode,
  input  wire logic [15:0] request_bytes,
  input  wire logic [3:0]  alloc_type,
  input  wire logic [15:0] block_offset,
  input  wire logic        cfg_wr_en,
  input  wire logic [16:0] cfg_wr_data,
  output logic             done,
  output logic [1:0]       status,
  output logic [15:0]      data_offset,
  output logic [15:0]      granted_bytes,
  output logic             page_empty,
  output logic             page_full
);
  import bpac_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_ALLOC, S_FCHK, S_FB, S_FP, S_FPN, S_NXRD, S_NX, S_NX2, S_NH, S_ROLL
  } state_t;

  state_t state;

  logic [16:0] page_bytes;
  logic [16:0] bump;
  logic [16:0] bump_next;
  logic [15:0] last_block;
  logic        last_valid;
  logic [HDR_AW-1:0] clr_idx;

  logic [15:0]          req_q;
  logic [TYPE_BITS-1:0] type_q;
  logic [15:0]          boff_q;
  logic [15:0]          bo;
  hdr_t                 bh;
  logic [17:0]          nx_q;
  logic                 nlt_q;
  logic [15:0]          nsize_q;

  logic              mem_we;
  logic [HDR_AW-1:0] mem_waddr;
  hdr_t              mem_wdata;
  logic [HDR_AW-1:0] mem_raddr;
  hdr_t              rd_data;
  hdr_t              rd_free;
  hdr_t              rd_grow;

  add_req_t add_req;
  add_rsp_t add_rsp;

  logic [16:0] pe;
  logic [16:0] left;
  logic [16:0] need_raw;
  logic [17:0] need_slack;
  logic [16:0] need;
  logic [15:0] gsize;
  logic        fail;
  logic        bad_off;
  logic        roll;
  logic [16:0] span;

  bpac_hdr_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  bpac_addu u_addu (
    .req  (add_req),
    .bump (bump),
    .rsp  (add_rsp)
  );

  assign busy = (state != S_IDLE);

  // Allocate sizing and free checks
  always_comb begin
    pe         = (page_bytes > 17'(PAGE_BYTES_MAX)) ? 17'(PAGE_BYTES_MAX) : page_bytes;
    left       = (pe > bump) ? (pe - bump) : 17'd0;
    need_raw   = ({1'b0, req_q} + 17'(BLOCK_HEADER_BYTES + ALIGN_BYTES - 1))
                 & ~17'(ALIGN_BYTES - 1);
    need_slack = {1'b0, need_raw} + 18'(BLOCK_HEADER_BYTES + POINTER_BYTES);
    fail       = need_raw > left;
    need       = (need_slack > {1'b0, left}) ? left : need_raw;
    gsize      = 16'(need - 17'(BLOCK_HEADER_BYTES));
    bad_off    = (boff_q < 16'(PAGE_HEADER_BYTES)) || ({1'b0, boff_q} >= bump) ||
                 (boff_q[ALIGN_SH-1:0] != ALIGN_SH'(PAGE_HEADER_BYTES % ALIGN_BYTES));
    roll       = last_valid && (last_block == bo);
    span       = add_rsp.sum[16:0];
    rd_free          = rd_data;
    rd_free.occupied = 1'b0;
    rd_grow          = rd_data;
    rd_grow.size     = add_rsp.sum[15:0];
  end

  // Drive the shared adder and the memory ports per step
  always_comb begin
    add_req   = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = rd_data;
    mem_raddr = '0;
    bump_next = bump;
    unique case (state)
      S_IDLE: begin
      end
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
        mem_wdata = '0;
      end
      S_ALLOC: begin
        mem_we    = !fail;
        mem_waddr = hdr_idx({1'b0, bump});
        mem_wdata = '{written: 1'b1, size: gsize, occupied: 1'b1, btype: type_q,
                      prev: last_block, prev_valid: last_valid};
        if (!fail) begin
          bump_next = bump + need;
        end
      end
      S_FCHK: begin
        mem_raddr = hdr_idx({2'b00, boff_q});
      end
      S_FB: begin
        add_req   = '{a: {1'b0, bo}, b: rd_data.size};
        mem_we    = rd_data.written && rd_data.occupied;
        mem_waddr = hdr_idx({2'b00, bo});
        mem_wdata.occupied = 1'b0;
        mem_raddr = hdr_idx({2'b00, rd_data.prev});
      end
      S_FP: begin
        add_req   = '{a: {1'b0, rd_data.size}, b: bh.size};
        mem_we    = rd_data.written && !rd_data.occupied;
        mem_waddr = hdr_idx({2'b00, bh.prev});
        mem_wdata.size = add_rsp.sum[15:0];
        mem_raddr = hdr_idx(nx_q);
      end
      S_FPN: begin
        mem_we    = 1'b1;
        mem_waddr = hdr_idx(nx_q);
        mem_wdata.prev       = bo;
        mem_wdata.prev_valid = 1'b1;
      end
      S_NXRD: begin
        add_req   = '{a: {1'b0, bo}, b: bh.size};
        mem_raddr = hdr_idx(add_rsp.sum);
      end
      S_NX: begin
        add_req   = '{a: nx_q[16:0], b: rd_data.size};
      end
      S_NX2: begin
        add_req   = '{a: {1'b0, bh.size}, b: nsize_q};
        mem_we    = 1'b1;
        mem_waddr = hdr_idx({2'b00, bo});
        mem_wdata = bh;
        mem_wdata.size = add_rsp.sum[15:0];
        mem_raddr = hdr_idx(nx_q);
      end
      S_NH: begin
        mem_we    = 1'b1;
        mem_waddr = hdr_idx(nx_q);
        mem_wdata.prev       = bo;
        mem_wdata.prev_valid = 1'b1;
      end
      S_ROLL: begin
        add_req = '{a: 17'd0, b: bh.size};
        if (roll) begin
          bump_next = (bump > span) ? (bump - span) : 17'd0;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer, page state and result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_idx    <= '0;
      page_bytes <= 17'(PAGE_BYTES_MAX);
      bump       <= 17'(PAGE_HEADER_BYTES);
      last_block <= '0;
      last_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_wr_en) begin
        // Page size write restarts the page and clears the headers
        page_bytes <= cfg_wr_data;
        bump       <= 17'(PAGE_HEADER_BYTES);
        last_block <= '0;
        last_valid <= 1'b0;
        clr_idx    <= '0;
        state      <= S_CLR;
      end else begin
        unique case (state)
          S_IDLE: begin
            if (start) begin
              req_q  <= request_bytes;
              type_q <= alloc_type[TYPE_BITS-1:0];
              boff_q <= block_offset;
              state  <= (opcode == OP_FREE) ? S_FCHK : S_ALLOC;
            end
          end
          S_CLR: begin
            clr_idx <= clr_idx + HDR_AW'(1);
            if (clr_idx == HDR_AW'(HDR_DEPTH - 1)) begin
              state <= S_IDLE;
            end
          end
          S_ALLOC: begin
            done          <= 1'b1;
            status        <= fail ? ST_NO_SPACE : ST_OK;
            data_offset   <= fail ? 16'd0 : 16'(bump + 17'(BLOCK_HEADER_BYTES));
            granted_bytes <= fail ? 16'd0 : gsize;
            page_empty    <= bump_next == 17'(PAGE_HEADER_BYTES);
            page_full     <= bump_next == pe;
            if (!fail) begin
              last_block <= bump[15:0];
              last_valid <= 1'b1;
              bump       <= bump_next;
            end
            state <= S_IDLE;
          end
          S_FCHK: begin
            bo <= boff_q;
            if (bad_off) begin
              done          <= 1'b1;
              status        <= ST_BAD_FREE;
              data_offset   <= '0;
              granted_bytes <= '0;
              page_empty    <= bump == 17'(PAGE_HEADER_BYTES);
              page_full     <= bump == pe;
              state         <= S_IDLE;
            end else begin
              state <= S_FB;
            end
          end
          S_FB: begin
            if (!rd_data.written || !rd_data.occupied) begin
              done          <= 1'b1;
              status        <= ST_BAD_FREE;
              data_offset   <= '0;
              granted_bytes <= '0;
              page_empty    <= bump == 17'(PAGE_HEADER_BYTES);
              page_full     <= bump == pe;
              state         <= S_IDLE;
            end else begin
              bh    <= rd_free;
              nx_q  <= add_rsp.sum;
              nlt_q <= add_rsp.below_bump;
              state <= rd_data.prev_valid ? S_FP : S_NXRD;
            end
          end
          S_FP: begin
            if (rd_data.written && !rd_data.occupied) begin
              bh <= rd_grow;
              bo <= bh.prev;
              if (nlt_q) begin
                state <= S_FPN;
              end else begin
                last_block <= bh.prev;
                last_valid <= 1'b1;
                state      <= S_NXRD;
              end
            end else begin
              state <= S_NXRD;
            end
          end
          S_FPN: begin
            state <= S_NXRD;
          end
          S_NXRD: begin
            nx_q  <= add_rsp.sum;
            state <= add_rsp.below_bump ? S_NX : S_ROLL;
          end
          S_NX: begin
            if (rd_data.written && !rd_data.occupied) begin
              nsize_q <= rd_data.size;
              nx_q    <= add_rsp.sum;
              nlt_q   <= add_rsp.below_bump;
              state   <= S_NX2;
            end else begin
              state <= S_ROLL;
            end
          end
          S_NX2: begin
            bh.size <= add_rsp.sum[15:0];
            if (nlt_q) begin
              state <= S_NH;
            end else begin
              last_block <= bo;
              last_valid <= 1'b1;
              state      <= S_ROLL;
            end
          end
          S_NH: begin
            state <= S_ROLL;
          end
          S_ROLL: begin
            if (roll) begin
              bump       <= bump_next;
              last_block <= bh.prev;
              last_valid <= bh.prev_valid;
            end
            done          <= 1'b1;
            status        <= ST_OK;
            data_offset   <= '0;
            granted_bytes <= '0;
            page_empty    <= bump_next == 17'(PAGE_HEADER_BYTES);
            page_full     <= bump_next == pe;
            state         <= S_IDLE;
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bpac_checker.sv =====
// ----------------------------------------------------------------------------
// bpac_checker
// Port level checks for the bump page allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bpac_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [1:0]  status,
  input wire logic [15:0] data_offset,
  input wire logic [15:0] granted_bytes
);
  import bpac_pkg::*;

  // An accepted beat occupies the block
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  // A result beat ends the operation
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("result beat outside an operation end");

  // Failed beats (status other than OK) carry no offset and no size
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> data_offset == 16'd0 && granted_bytes == 16'd0)
    else $error("failed beat carries payload");

  // Only defined status codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> status == ST_OK || status == ST_NO_SPACE || status == ST_BAD_FREE)
    else $error("undefined status code");

endmodule

bind bump_page_allocator_coalesce bpac_checker u_bpac_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .status        (status),
  .data_offset   (data_offset),
  .granted_bytes (granted_bytes)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bump page allocator with free coalescing.
// An in-bench allocator model predicts every result beat; a monitor compares
// each done beat against the oldest prediction. Directed tests cover page
// extremes, a full page end, bad frees and merges; a random phase mixes
// allocates and frees over several page sizes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import bpac_pkg::*;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        opcode;
  logic [15:0] request_bytes;
  logic [3:0]  alloc_type;
  logic [15:0] block_offset;
  logic        cfg_wr_en;
  logic [16:0] cfg_wr_data;
  logic        done;
  logic [1:0]  status;
  logic [15:0] data_offset;
  logic [15:0] granted_bytes;
  logic        page_empty;
  logic        page_full;

  bump_page_allocator_coalesce DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .request_bytes(request_bytes), .alloc_type(alloc_type),
    .block_offset(block_offset), .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data), .done(done), .status(status),
    .data_offset(data_offset), .granted_bytes(granted_bytes),
    .page_empty(page_empty), .page_full(page_full)
  );

  typedef struct packed {
    logic [1:0]  st;
    logic [15:0] data;
    logic [15:0] granted;
    logic        empty;
    logic        full;
  } alloc_result_t;

  // Allocator model state
  bit          hdr_written [HDR_DEPTH];
  bit          hdr_occupied[HDR_DEPTH];
  bit          hdr_prev_ok [HDR_DEPTH];
  int unsigned hdr_size    [HDR_DEPTH];
  int unsigned hdr_prev    [HDR_DEPTH];
  logic [3:0]  hdr_type    [HDR_DEPTH];
  int unsigned bump;
  int unsigned tail_block;
  bit          tail_ok;
  int unsigned page_size;

  alloc_result_t pending_results[$];
  int unsigned   live_blocks[$];
  int            mismatches;
  int            failures;
  int            n_items, n_allocs_ok, n_frees_ok, n_bad_frees, n_no_space;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  function automatic int unsigned slot_of(input int unsigned off);
    int unsigned s;
    s = off / ALIGN_BYTES;
    if (s >= HDR_DEPTH) begin
      s = HDR_DEPTH - 1;
    end
    return s;
  endfunction

  function automatic int unsigned eff_page();
    return (page_size < PAGE_BYTES_MAX) ? page_size : PAGE_BYTES_MAX;
  endfunction

  // Restart the page: no blocks, every header unwritten
  function automatic void page_restart(input int unsigned bytes);
    page_size = bytes & 17'h1FFFF;
    foreach (hdr_written[i]) begin
      hdr_written[i] = 1'b0;
      hdr_occupied[i] = 1'b0;
      hdr_prev_ok[i] = 1'b0;
      hdr_size[i] = 0;
      hdr_prev[i] = 0;
      hdr_type[i] = '0;
    end
    bump = PAGE_HEADER_BYTES;
    tail_block = 0;
    tail_ok = 1'b0;
    live_blocks.delete();
  endfunction

  // Free a block and merge it with free neighbors; returns status code
  function automatic logic [1:0] free_block(input int unsigned off);
    int unsigned bo, b, p, nx, n, nn, span;
    if (off < PAGE_HEADER_BYTES || off >= bump ||
        (off % ALIGN_BYTES) != (PAGE_HEADER_BYTES % ALIGN_BYTES)) begin
      return ST_BAD_FREE;
    end
    bo = off;
    b = slot_of(bo);
    if (!hdr_written[b] || !hdr_occupied[b]) begin
      return ST_BAD_FREE;
    end
    hdr_occupied[b] = 1'b0;
    // merge into a free previous block
    if (hdr_prev_ok[b]) begin
      p = slot_of(hdr_prev[b]);
      if (hdr_written[p] && !hdr_occupied[p]) begin
        nx = bo + BLOCK_HEADER_BYTES + hdr_size[b];
        if (nx < bump) begin
          n = slot_of(nx);
          hdr_prev[n] = hdr_prev[b];
          hdr_prev_ok[n] = 1'b1;
        end else begin
          tail_block = hdr_prev[b];
          tail_ok = 1'b1;
        end
        hdr_size[p] = (hdr_size[p] + hdr_size[b] + BLOCK_HEADER_BYTES) & 16'hFFFF;
        bo = hdr_prev[b];
        b = p;
      end
    end
    // absorb a free next block
    nx = bo + BLOCK_HEADER_BYTES + hdr_size[b];
    if (nx < bump) begin
      n = slot_of(nx);
      if (hdr_written[n] && !hdr_occupied[n]) begin
        nn = nx + BLOCK_HEADER_BYTES + hdr_size[n];
        hdr_size[b] = (hdr_size[b] + hdr_size[n] + BLOCK_HEADER_BYTES) & 16'hFFFF;
        if (nn < bump) begin
          hdr_prev[slot_of(nn)] = bo;
          hdr_prev_ok[slot_of(nn)] = 1'b1;
        end else begin
          tail_block = bo;
          tail_ok = 1'b1;
        end
      end
    end
    // roll the bump pointer back over a free tail
    if (tail_ok && tail_block == bo) begin
      span = hdr_size[b] + BLOCK_HEADER_BYTES;
      bump = (bump > span) ? bump - span : 0;
      tail_block = hdr_prev[b];
      tail_ok = hdr_prev_ok[b];
    end
    return ST_OK;
  endfunction

  // Predict one beat of result and advance the model
  function automatic alloc_result_t allocator_step(input logic op, input int unsigned req,
                                                   input logic [3:0] typ,
                                                   input int unsigned boff);
    alloc_result_t r;
    int unsigned need, left, pe, h;
    r = '0;
    pe = eff_page();
    if (op == OP_ALLOC) begin
      left = (pe > bump) ? pe - bump : 0;
      need = (req + BLOCK_HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
      if (need > left) begin
        r.st = ST_NO_SPACE;
      end else begin
        if (need + BLOCK_HEADER_BYTES + POINTER_BYTES > left) begin
          need = left;
        end
        h = slot_of(bump);
        hdr_written[h] = 1'b1;
        hdr_occupied[h] = 1'b1;
        hdr_size[h] = (need - BLOCK_HEADER_BYTES) & 16'hFFFF;
        hdr_type[h] = typ;
        hdr_prev[h] = tail_block;
        hdr_prev_ok[h] = tail_ok;
        r.data = 16'(bump + BLOCK_HEADER_BYTES);
        r.granted = 16'(hdr_size[h]);
        live_blocks.push_back(bump);
        tail_block = bump & 16'hFFFF;
        tail_ok = 1'b1;
        bump += need;
      end
    end else begin
      r.st = free_block(boff);
      if (r.st == ST_OK) begin
        foreach (live_blocks[i]) begin
          if (live_blocks[i] == boff) begin
            live_blocks.delete(i);
            break;
          end
        end
      end
    end
    r.empty = (bump == PAGE_HEADER_BYTES);
    r.full = (bump == pe);
    return r;
  endfunction

  // Send one beat after a random gap; predict it at the accepting edge
  task automatic send_op(input logic op, input logic [15:0] req, input logic [3:0] typ,
                         input logic [15:0] boff);
    int unsigned gap;
    alloc_result_t r;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
    repeat (gap) @(negedge clk);
    while (busy) @(negedge clk);
    start = 1'b1;
    opcode = op;
    request_bytes = req;
    alloc_type = typ;
    block_offset = boff;
    @(posedge clk);
    r = allocator_step(op, req, typ, boff);
    pending_results.push_back(r);
    n_items++;
    case (r.st)
      ST_NO_SPACE: n_no_space++;
      ST_BAD_FREE: n_bad_frees++;
      default: if (op == OP_ALLOC) n_allocs_ok++; else n_frees_ok++;
    endcase
    @(negedge clk);
    start = 1'b0;
  endtask

  // Hold off until every predicted beat has arrived
  task automatic drain();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_page_size(input int unsigned bytes);
    drain();
    cfg_wr_en = 1'b1;
    cfg_wr_data = 17'(bytes);
    @(posedge clk);
    page_restart(bytes);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic alloc(input int unsigned req);
    send_op(OP_ALLOC, 16'(req), 4'($urandom), 16'($urandom));
  endtask

  task automatic free_at(input int unsigned off);
    send_op(OP_FREE, 16'($urandom), 4'($urandom), 16'(off));
  endtask

  task automatic free_random_live();
    if (live_blocks.size() != 0) begin
      free_at(live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
    end
  endtask

  // A free below the page header, misaligned, at or past bump, or at a written header
  task automatic free_bad();
    int unsigned off;
    off = PAGE_HEADER_BYTES + ALIGN_BYTES * $urandom_range(0, 255);
    case ($urandom_range(0, 3))
      0: free_at($urandom_range(0, PAGE_HEADER_BYTES - 1));
      1: free_at(PAGE_HEADER_BYTES + 1 + 16 * $urandom_range(0, 20));
      2: free_at($urandom_range(bump < 65535 ? bump : 65535, 65535));
      default: begin
        if (off < bump && hdr_written[slot_of(off)]) begin
          free_at(off);
        end else begin
          free_at($urandom_range(0, PAGE_HEADER_BYTES - 1));
        end
      end
    endcase
  endtask

  // Field extremes, every opcode, double free and merges both ways
  task automatic test_directed_basic();
    alloc(0);
    alloc(1);
    alloc(100);
    alloc(16'hFFFF);
    send_op(OP_ALLOC, 16'd32, 4'hF, 16'hFFFF);
    send_op(OP_ALLOC, 16'd48, 4'h0, 16'h0000);
    free_at(PAGE_HEADER_BYTES + 16);      // free the second block
    free_at(PAGE_HEADER_BYTES + 16);      // same one again
    free_at(PAGE_HEADER_BYTES + 16 + 32); // merges with free previous
    free_at(PAGE_HEADER_BYTES);           // merges with free next
    free_at(16'hFFFF);
    free_at(0);
    free_at(PAGE_HEADER_BYTES + 3);
    free_random_live();
    free_random_live();
  endtask

  // Fill a full 64 KiB page: a large block, a remainder grab, then no space
  task automatic test_page_end();
    write_page_size(65536);
    alloc(65536 - PAGE_HEADER_BYTES - 2 * BLOCK_HEADER_BYTES - BLOCK_HEADER_BYTES);
    alloc(0);
    alloc(0);
    free_random_live();
    free_random_live();
  endtask

  // Small pages, clamped sizes, remainder grab
  task automatic test_page_sizes();
    write_page_size(32);
    alloc(0);
    free_at(PAGE_HEADER_BYTES);
    write_page_size(256);
    alloc(100);
    alloc(40);
    alloc(0);
    free_random_live();
    write_page_size(17'h1FFFF);
    alloc(16'hFFFF);
    alloc(65000);
    free_random_live();
  endtask

  // Mixed random traffic over several page sizes
  task automatic test_random(input int count);
    int k;
    for (int i = 0; i < count; i++) begin
      if (i % 130 == 0) begin
        case ($urandom_range(0, 3))
          0: write_page_size($urandom_range(256, 2048));
          1: write_page_size(65536);
          2: write_page_size($urandom_range(0, 17'h1FFFF));
          default: write_page_size($urandom_range(2048, 16384));
        endcase
      end
      if (i == count / 2) begin
        drain();
      end
      k = $urandom_range(0, 99);
      if (k < 50) alloc($urandom_range(0, $urandom_range(0, 3) == 0 ? 2000 : 120));
      else if (k < 80) free_random_live();
      else if (k < 92) free_bad();
      else alloc($urandom_range(0, 16'hFFFF));
    end
  endtask

  // Check every result beat against the oldest prediction
  always @(posedge clk) begin
    alloc_result_t want;
    alloc_result_t got;
    if (!rst && done) begin
      got = '{status, data_offset, granted_bytes, page_empty, page_full};
      if (pending_results.size() == 0) begin
        failures++;
        if (mismatches++ < 10) $display("unexpected result beat %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          failures++;
          if (mismatches++ < 10) begin
            $display("mismatch: expected st=%0d data=%0h gr=%0h e=%0b f=%0b",
                     want.st, want.data, want.granted, want.empty, want.full);
            $display("          actual   st=%0d data=%0h gr=%0h e=%0b f=%0b",
                     got.st, got.data, got.granted, got.empty, got.full);
          end
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    opcode = OP_ALLOC;
    request_bytes = '0;
    alloc_type = '0;
    block_offset = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    mismatches = 0;
    failures = 0;
    n_items = 0;
    n_allocs_ok = 0;
    n_frees_ok = 0;
    n_bad_frees = 0;
    n_no_space = 0;
    page_restart(65536);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_basic();
    test_page_end();
    test_page_sizes();
    test_random(620);

    drain();
    repeat (20) @(negedge clk);
    if (pending_results.size() != 0) begin
      failures++;
    end
    $display("covered %0d ops: %0d allocs ok, %0d frees ok, %0d bad frees, %0d no space",
             n_items, n_allocs_ok, n_frees_ok, n_bad_frees, n_no_space);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
